// ===== src/afcd_pkg.sv =====
`default_nettype none
package afcd_pkg;

    localparam int unsigned ADDR_W = 40;
    localparam int unsigned COUNT_W = 9;

    localparam logic [ADDR_W-1:0] ADDR_RESET = 40'h3030303030;
    localparam logic [7:0] BROADCAST_CHAR = 8'h39;
    localparam logic [6:0] CMD_FIRST = 7'h40;
    localparam logic [6:0] CMD_LAST = 7'h45;
    localparam logic [COUNT_W-1:0] PAYLOAD_START = 9'd15;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [COUNT_W-1:0] POS_CMD_HI = 9'd11;
    localparam logic [COUNT_W-1:0] POS_CMD_LO = 9'd12;
    localparam logic [COUNT_W-1:0] POS_LEN_HI = 9'd13;
    localparam logic [COUNT_W-1:0] POS_LEN_LO = 9'd14;
    localparam logic [COUNT_W-1:0] POS_ADDR_FIRST = 9'd1;
    localparam logic [COUNT_W-1:0] POS_ADDR_LAST = 9'd10;
    localparam logic [COUNT_W:0] MIN_FRAME = 10'd18;

    localparam logic CFG_ADDR_HIGH = 1'b0;
    localparam logic CFG_ADDR_LOW = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] ST_DISPATCH = 3'd0;
    localparam logic [2:0] ST_CHECK_ERR = 3'd1;
    localparam logic [2:0] ST_ADDR_MISMATCH = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_CMD = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;

    localparam logic [2:0] NO_HANDLER = 3'd6;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_word_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic [6:0] command_code;
        logic       is_response;
        logic [2:0] handler_index;
        logic [7:0] payload_length;
        logic       broadcast_addr;
    } result_t;

    typedef struct packed {
        logic       err;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.err = 1'b0;
        h.val = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.val = c[3:0];
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            h.val = c[3:0] + 4'd9;
        end
        else
        begin
            h.err = 1'b1;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== src/afcd_stream_if.sv =====
`default_nettype none
interface afcd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/afcd_frame.sv =====
`default_nettype none
module afcd_frame (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            frame_end,
    input  wire logic [afcd_pkg::ADDR_W-1:0]     own_address_high,
    input  wire logic [afcd_pkg::ADDR_W-1:0]     own_address_low,
    output logic                                 has_result,
    output afcd_pkg::result_t                    result
);

    logic [afcd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] recent_reg, recent_next;
    logic        own_match_reg, own_match_next;
    logic        bcast_reg, bcast_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  chk_reg, chk_next;
    logic        herr_reg, herr_next;

    logic [2*afcd_pkg::ADDR_W-1:0] addr_all;
    logic [3:0]  addr_sel;
    logic [7:0]  own_char;
    logic [afcd_pkg::COUNT_W-1:0] chk_pos;
    logic [afcd_pkg::COUNT_W-1:0] chk_pos1;
    afcd_pkg::hex_t hx;
    logic [afcd_pkg::COUNT_W:0] total;
    logic [afcd_pkg::COUNT_W:0] need;
    logic [7:0]  xr;
    logic [6:0]  cmd;
    logic [2:0]  status;
    logic [2:0]  handler;
    logic        in_payload;

    assign addr_all = {own_address_high, own_address_low};
    assign addr_sel = 4'd10 - count_reg[3:0];
    assign own_char = addr_all[{addr_sel, 3'b000} +: 8];
    assign chk_pos = afcd_pkg::PAYLOAD_START + {1'b0, len_reg};
    assign chk_pos1 = chk_pos + 9'd1;
    assign hx = afcd_pkg::hex_digit(rx_byte);

    always_comb
    begin
        own_match_next = own_match_reg;
        bcast_next = bcast_reg;
        ctrl_next = ctrl_reg;
        len_next = len_reg;
        chk_next = chk_reg;
        herr_next = herr_reg;
        if (count_reg >= afcd_pkg::POS_ADDR_FIRST && count_reg <= afcd_pkg::POS_ADDR_LAST)
        begin
            if (rx_byte != own_char)
            begin
                own_match_next = 1'b0;
            end
            if (rx_byte != afcd_pkg::BROADCAST_CHAR)
            begin
                bcast_next = 1'b0;
            end
        end
        else if (count_reg == afcd_pkg::POS_CMD_HI)
        begin
            ctrl_next = {hx.val, 4'd0};
            herr_next = herr_reg | hx.err;
        end
        else if (count_reg == afcd_pkg::POS_CMD_LO)
        begin
            ctrl_next = {ctrl_reg[7:4], hx.val};
            herr_next = herr_reg | hx.err;
        end
        else if (count_reg == afcd_pkg::POS_LEN_HI)
        begin
            len_next = {hx.val, 4'd0};
            herr_next = herr_reg | hx.err;
        end
        else if (count_reg == afcd_pkg::POS_LEN_LO)
        begin
            len_next = {len_reg[7:4], hx.val};
            herr_next = herr_reg | hx.err;
        end
        else if (count_reg == chk_pos)
        begin
            chk_next = {hx.val, 4'd0};
            herr_next = herr_reg | hx.err;
        end
        else if (count_reg == chk_pos1)
        begin
            chk_next = {chk_reg[7:4], hx.val};
            herr_next = herr_reg | hx.err;
        end
    end

    assign total = {1'b0, count_reg} + 10'd1;
    assign need = afcd_pkg::MIN_FRAME + {2'b00, len_next};
    assign xr = xor_reg ^ recent_reg[7:0] ^ recent_reg[15:8];
    assign cmd = ctrl_next[6:0];
    assign in_payload = (count_reg >= afcd_pkg::PAYLOAD_START) && (count_reg < chk_pos);

    always_comb
    begin
        handler = afcd_pkg::NO_HANDLER;
        if (total < need)
        begin
            status = afcd_pkg::ST_SHORT;
        end
        else if (herr_next || xr != chk_next)
        begin
            status = afcd_pkg::ST_CHECK_ERR;
        end
        else if (!own_match_next && !bcast_next)
        begin
            status = afcd_pkg::ST_ADDR_MISMATCH;
        end
        else if (cmd >= afcd_pkg::CMD_FIRST && cmd <= afcd_pkg::CMD_LAST)
        begin
            status = afcd_pkg::ST_DISPATCH;
            handler = cmd[2:0];
        end
        else
        begin
            status = afcd_pkg::ST_UNKNOWN_CMD;
        end
    end

    always_comb
    begin
        result = '0;
        if (frame_end)
        begin
            has_result = 1'b1;
            result.result_kind = afcd_pkg::KIND_VERDICT;
            result.status = status;
            result.command_code = cmd;
            result.is_response = ctrl_next[7];
            result.handler_index = handler;
            result.payload_length = len_next;
            result.broadcast_addr = bcast_next;
        end
        else
        begin
            has_result = in_payload;
            result.result_kind = afcd_pkg::KIND_PAYLOAD;
            result.payload_byte = rx_byte;
        end
    end

    always_comb
    begin
        if (frame_end)
        begin
            count_next = '0;
            xor_next = '0;
            recent_next = '0;
        end
        else
        begin
            count_next = (count_reg < afcd_pkg::COUNT_MAX) ? count_reg + 9'd1 : count_reg;
            xor_next = xor_reg ^ rx_byte;
            recent_next = {recent_reg[7:0], rx_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            xor_reg <= '0;
            recent_reg <= '0;
            own_match_reg <= 1'b1;
            bcast_reg <= 1'b1;
            ctrl_reg <= '0;
            len_reg <= '0;
            chk_reg <= '0;
            herr_reg <= 1'b0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            xor_reg <= xor_next;
            recent_reg <= recent_next;
            if (frame_end)
            begin
                own_match_reg <= 1'b1;
                bcast_reg <= 1'b1;
                ctrl_reg <= '0;
                len_reg <= '0;
                chk_reg <= '0;
                herr_reg <= 1'b0;
            end
            else
            begin
                own_match_reg <= own_match_next;
                bcast_reg <= bcast_next;
                ctrl_reg <= ctrl_next;
                len_reg <= len_next;
                chk_reg <= chk_next;
                herr_reg <= herr_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/ascii_frame_checker_dispatcher.sv =====
`default_nettype none
// Frame checker and command dispatcher for an ASCII link.
// frame: one received byte per word, with frame_end on the last byte of a frame.
// result: one word per payload byte (result_kind 0) and one verdict word
//   (result_kind 1) on the last byte; other bytes give no word.
// cfg_we/cfg_index/cfg_data: write own_address_high (index 0) or
//   own_address_low (index 1); write only while no frame is in progress.
// Throughput: one byte per cycle with no gaps between frames, unless stalled.
// Output: a result word is valid in the cycle after its byte is accepted
//   unless an earlier word still waits in the output register; the whole check
//   and decode of a byte is combinational, ahead of the output register.
// Stall: a two-word output stage (output register plus skid register) keeps
//   frame.ready high while one result waits; frame.ready drops only when both
//   are full and stays low until the receiver takes a word.
// Reset: all frame state is cleared, both address registers read "00000",
//   and no result word is valid.
module ascii_frame_checker_dispatcher (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    afcd_stream_if.sink                      frame,
    afcd_stream_if.source                    result,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [afcd_pkg::ADDR_W-1:0] cfg_data
);

    logic [afcd_pkg::ADDR_W-1:0] addr_high_reg;
    logic [afcd_pkg::ADDR_W-1:0] addr_low_reg;

    logic              accept;
    logic              has_result;
    afcd_pkg::in_word_t in_word;
    afcd_pkg::result_t new_result;
    afcd_pkg::result_t out_reg;
    afcd_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              push;
    logic              out_fire;

    assign in_word = frame.data;
    assign frame.ready = !skid_valid_reg;
    assign accept = frame.valid && !skid_valid_reg;
    assign push = accept && has_result;
    assign out_fire = out_valid_reg && result.ready;

    assign result.valid = out_valid_reg;
    assign result.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_high_reg <= afcd_pkg::ADDR_RESET;
            addr_low_reg <= afcd_pkg::ADDR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == afcd_pkg::CFG_ADDR_HIGH)
            begin
                addr_high_reg <= cfg_data;
            end
            else
            begin
                addr_low_reg <= cfg_data;
            end
        end
    end

    afcd_frame u_frame (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .rx_byte          (in_word.rx_byte),
        .frame_end        (in_word.frame_end),
        .own_address_high (addr_high_reg),
        .own_address_low  (addr_low_reg),
        .has_result       (has_result),
        .result           (new_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= new_result;
            end
            else
            begin
                out_reg <= new_result;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/afcd_checker.sv =====
`default_nettype none
module afcd_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire afcd_pkg::result_t out_data
);

    assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == afcd_pkg::KIND_VERDICT
        && out_data.status == afcd_pkg::ST_DISPATCH
        |-> out_data.command_code == afcd_pkg::CMD_FIRST + {4'd0, out_data.handler_index}
        && out_data.handler_index != afcd_pkg::NO_HANDLER)
        else $error("dispatch handler does not match command");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == afcd_pkg::KIND_VERDICT
        && out_data.status != afcd_pkg::ST_DISPATCH
        |-> out_data.handler_index == afcd_pkg::NO_HANDLER && out_data.payload_byte == 8'd0)
        else $error("rejected verdict carries a handler");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid) && out_valid)
        else $error("input stalled with an empty output stage");

endmodule

bind ascii_frame_checker_dispatcher afcd_checker u_afcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (frame.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
`default_nettype wire
